[design/sbt_pkg.sv]
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, codes and character helpers of the source byte tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int RES_MAX         = 4;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam logic [15:0] COL_MAX  = 16'hFFFF;
	localparam logic [15:0] LEN_MAX  = 16'hFFFF;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LOWER = 8'h20;

	// scan modes
	localparam logic [4:0] M_IDLE    = 5'd0;
	localparam logic [4:0] M_PLUS    = 5'd1;
	localparam logic [4:0] M_MINUS   = 5'd2;
	localparam logic [4:0] M_SLASH   = 5'd3;
	localparam logic [4:0] M_EQ      = 5'd4;
	localparam logic [4:0] M_LESS    = 5'd5;
	localparam logic [4:0] M_GREATER = 5'd6;
	localparam logic [4:0] M_DOT     = 5'd7;
	localparam logic [4:0] M_ZERO    = 5'd8;
	localparam logic [4:0] M_NINT    = 5'd9;
	localparam logic [4:0] M_NDOT    = 5'd10;
	localparam logic [4:0] M_NFRAC   = 5'd11;
	localparam logic [4:0] M_NE      = 5'd12;
	localparam logic [4:0] M_NESIGN  = 5'd13;
	localparam logic [4:0] M_NEXP    = 5'd14;
	localparam logic [4:0] M_BSTART  = 5'd15;
	localparam logic [4:0] M_BDIG    = 5'd16;
	localparam logic [4:0] M_IDENT   = 5'd17;
	localparam logic [4:0] M_STR     = 5'd18;
	localparam logic [4:0] M_STRESC  = 5'd19;
	localparam logic [4:0] M_COPEN   = 5'd20;
	localparam logic [4:0] M_CESC    = 5'd21;
	localparam logic [4:0] M_CCLOSE  = 5'd22;
	localparam logic [4:0] M_COMMENT = 5'd23;

	// token classes
	localparam logic [4:0] TK_EOF     = 5'd0;
	localparam logic [4:0] TK_NEWLINE = 5'd1;
	localparam logic [4:0] TK_ADD     = 5'd2;
	localparam logic [4:0] TK_INCR    = 5'd3;
	localparam logic [4:0] TK_MINUS   = 5'd4;
	localparam logic [4:0] TK_DECR    = 5'd5;
	localparam logic [4:0] TK_ARROW   = 5'd6;
	localparam logic [4:0] TK_MULT    = 5'd7;
	localparam logic [4:0] TK_DIV     = 5'd8;
	localparam logic [4:0] TK_ASSIGN  = 5'd9;
	localparam logic [4:0] TK_EQ      = 5'd10;
	localparam logic [4:0] TK_LESS    = 5'd11;
	localparam logic [4:0] TK_SHL     = 5'd12;
	localparam logic [4:0] TK_GREATER = 5'd13;
	localparam logic [4:0] TK_SHR     = 5'd14;
	localparam logic [4:0] TK_LPAREN  = 5'd15;
	localparam logic [4:0] TK_RPAREN  = 5'd16;
	localparam logic [4:0] TK_LBRACE  = 5'd17;
	localparam logic [4:0] TK_RBRACE  = 5'd18;
	localparam logic [4:0] TK_LBRACK  = 5'd19;
	localparam logic [4:0] TK_RBRACK  = 5'd20;
	localparam logic [4:0] TK_COMMA   = 5'd21;
	localparam logic [4:0] TK_DOT     = 5'd22;
	localparam logic [4:0] TK_COLON   = 5'd23;
	localparam logic [4:0] TK_NUMBER  = 5'd24;
	localparam logic [4:0] TK_BINARY  = 5'd25;
	localparam logic [4:0] TK_IDENT   = 5'd26;
	localparam logic [4:0] TK_STRING  = 5'd27;
	localparam logic [4:0] TK_CHAR    = 5'd28;

	// error codes
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_UNEXPECTED  = 4'd1;
	localparam logic [3:0] ERR_STR_ESC     = 4'd2;
	localparam logic [3:0] ERR_STR_UNTERM  = 4'd3;
	localparam logic [3:0] ERR_CHAR_UNTERM = 4'd4;
	localparam logic [3:0] ERR_CHAR_INCOMP = 4'd5;
	localparam logic [3:0] ERR_CHAR_ESC    = 4'd6;
	localparam logic [3:0] ERR_EXPONENT    = 4'd7;
	localparam logic [3:0] ERR_BINARY      = 4'd8;

	typedef struct packed {
		logic [4:0]  token_class;
		logic [3:0]  error_code;
		logic [23:0] start_offset;
		logic [15:0] token_length;
		logic [23:0] line_number;
		logic [15:0] column_number;
		logic [7:0]  char_value;
		logic        last_of_run;
	} res_t;

	function automatic logic is_dig(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alp(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_bin(logic [7:0] c);
		return (c == "0") || (c == "1");
	endfunction

	// {ok, value}
	function automatic logic [8:0] esc_decode(logic [7:0] c);
		logic [8:0] r;
		case (c)
			"n":     r = {1'b1, 8'd10};
			"t":     r = {1'b1, 8'd9};
			"r":     r = {1'b1, 8'd13};
			"\\":    r = {1'b1, 8'd92};
			"'":     r = {1'b1, 8'd39};
			"\"":    r = {1'b1, 8'd34};
			"0":     r = {1'b1, 8'd0};
			default: r = {1'b0, 8'd0};
		endcase
		return r;
	endfunction

	// {emits, class} for a pending token whose end is settled
	function automatic logic [5:0] close_cls(logic [4:0] m);
		logic [5:0] r;
		case (m)
			M_PLUS:    r = {1'b1, TK_ADD};
			M_MINUS:   r = {1'b1, TK_MINUS};
			M_SLASH:   r = {1'b1, TK_DIV};
			M_EQ:      r = {1'b1, TK_ASSIGN};
			M_LESS:    r = {1'b1, TK_LESS};
			M_GREATER: r = {1'b1, TK_GREATER};
			M_DOT:     r = {1'b1, TK_DOT};
			M_ZERO:    r = {1'b1, TK_NUMBER};
			M_NINT:    r = {1'b1, TK_NUMBER};
			M_NFRAC:   r = {1'b1, TK_NUMBER};
			M_NEXP:    r = {1'b1, TK_NUMBER};
			M_BDIG:    r = {1'b1, TK_BINARY};
			M_IDENT:   r = {1'b1, TK_IDENT};
			default:   r = {1'b0, TK_EOF};
		endcase
		return r;
	endfunction

endpackage

[design/sbt_if.sv]
// ----------------------------------------------------------------------------
// sbt_if
// Valid/ready channels of the source byte tokenizer: source bytes and tokens.
// ----------------------------------------------------------------------------
interface sbt_src_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] source_byte;

	modport source (output valid, cmd, source_byte, input ready);
	modport sink (input valid, cmd, source_byte, output ready);
endinterface

interface sbt_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_class;
	logic [3:0]  error_code;
	logic [23:0] start_offset;
	logic [15:0] token_length;
	logic [23:0] line_number;
	logic [15:0] column_number;
	logic [7:0]  char_value;
	logic        last_of_run;

	modport source (output valid, token_class, error_code, start_offset, token_length,
		line_number, column_number, char_value, last_of_run, input ready);
	modport sink (input valid, token_class, error_code, start_offset, token_length,
		line_number, column_number, char_value, last_of_run, output ready);
endinterface

[design/source_byte_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexer: source bytes in, tokens and lexical errors out.
// ----------------------------------------------------------------------------
// source carries one item per byte (cmd 0) or an end of source mark (cmd 1).
// tokens carries result items; the last one caused by a source item has
// last_of_run set. A source item makes zero to four results.
// a source item lands in an input register, is scanned by the classification
// logic and its results load a four-entry result bundle that drains one item
// per cycle while tokens is ready. throughput is one source item per cycle
// while each item makes at most one result and tokens does not stall; an item
// with more results holds the scanner until the bundle has drained through the
// single result port.
// end of source flushes pending tokens, emits eof and returns the scanner to
// its reset state. reset clears the scanner state (line 1, column 1, offset 0)
// and empties both registers. when tokens stalls, the bundle holds, the input
// register fills and source.ready drops.
// ----------------------------------------------------------------------------
module source_byte_tokenizer #(
	parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sbt_src_if.sink   source,
	sbt_tok_if.source tokens
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	function automatic logic [OFFSET_BITS-1:0] inc_off(logic [OFFSET_BITS-1:0] x);
		return (x != OFF_MAX) ? x + 1'b1 : x;
	endfunction

	function automatic logic [15:0] inc_col(logic [15:0] x);
		return (x != sbt_pkg::COL_MAX) ? x + 1'b1 : x;
	endfunction

	function automatic sbt_pkg::res_t mk(logic [4:0] cls, logic [3:0] err, logic [7:0] cv,
		logic [OFFSET_BITS-1:0] ts, logic [OFFSET_BITS-1:0] bo, logic [23:0] ln,
		logic [15:0] tc);
		sbt_pkg::res_t r;
		logic [OFFSET_BITS-1:0] d;
		d = bo - ts;
		r.token_class   = (err != sbt_pkg::ERR_NONE) ? sbt_pkg::TK_EOF : cls;
		r.error_code    = err;
		r.start_offset  = 24'(ts);
		r.token_length  = (d > OFFSET_BITS'(sbt_pkg::LEN_MAX)) ? sbt_pkg::LEN_MAX : d[15:0];
		r.line_number   = ln;
		r.column_number = tc;
		r.char_value    = cv;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	// input register
	logic       v_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	// scanner state
	logic [4:0]             mode_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [23:0]            line_q;
	logic [15:0]            col_q;
	logic [OFFSET_BITS-1:0] tso_q;
	logic [15:0]            tscol_q;
	logic [7:0]             lit_q;
	logic                   lnl_q;

	// result bundle
	sbt_pkg::res_t b_q [sbt_pkg::RES_MAX];
	logic [2:0]    bcnt_q;
	logic [1:0]    bidx_q;

	// next state
	logic [4:0]             n_mode;
	logic [OFFSET_BITS-1:0] n_off;
	logic [23:0]            n_line;
	logic [15:0]            n_col;
	logic [OFFSET_BITS-1:0] n_tso;
	logic [15:0]            n_tscol;
	logic [7:0]             n_lit;
	logic                   n_lnl;
	sbt_pkg::res_t          n_res [sbt_pkg::RES_MAX];
	logic [2:0]             n_cnt;

	logic out_fire;
	logic out_last;
	logic b_free;
	logic proc;

	always_comb begin : scan
		logic [4:0]             m;
		logic [OFFSET_BITS-1:0] off;
		logic [23:0]            ln;
		logic [15:0]            col;
		logic [OFFSET_BITS-1:0] ts;
		logic [15:0]            tc;
		logic [7:0]             lit;
		logic                   lnl;
		logic [2:0]             cnt;
		logic [7:0]             c;
		logic                   done;
		logic                   close;
		logic                   e_go;
		sbt_pkg::res_t          e_res;
		logic [8:0]             ev;
		logic [5:0]             cc;

		m     = mode_q;
		off   = off_q;
		ln    = line_q;
		col   = col_q;
		ts    = tso_q;
		tc    = tscol_q;
		lit   = lit_q;
		lnl   = lnl_q;
		cnt   = 3'd0;
		c     = byte_s1;
		done  = 1'b0;
		close = 1'b0;
		e_go  = 1'b0;
		e_res = '0;
		ev    = '0;
		cc    = '0;
		for (int k = 0; k < sbt_pkg::RES_MAX; k++) begin
			n_res[k] = '0;
		end

		for (int p = 0; p < 4; p++) begin
			if (!done) begin
				close = 1'b0;
				e_go  = 1'b0;
				if (cmd_s1) begin
					// end of source flush
					case (m)
						sbt_pkg::M_NDOT, sbt_pkg::M_NE: begin
							e_go  = 1'b1;
							e_res = mk(sbt_pkg::TK_NUMBER, sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
							ts    = off;
							tc    = col;
							off   = inc_off(off);
							col   = inc_col(col);
							m     = (m == sbt_pkg::M_NDOT) ? sbt_pkg::M_DOT : sbt_pkg::M_IDENT;
						end
						sbt_pkg::M_NESIGN: begin
							off   = inc_off(inc_off(off));
							col   = inc_col(inc_col(col));
							e_go  = 1'b1;
							e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_EXPONENT, 8'd0, ts, off, ln, tc);
							done  = 1'b1;
						end
						sbt_pkg::M_BSTART: begin
							e_go  = 1'b1;
							e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_BINARY, 8'd0, ts, off, ln, tc);
							done  = 1'b1;
						end
						sbt_pkg::M_STR, sbt_pkg::M_STRESC: begin
							e_go  = 1'b1;
							e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_STR_UNTERM, 8'd0, ts, off, ln,
								tc);
							done  = 1'b1;
						end
						sbt_pkg::M_COPEN, sbt_pkg::M_CCLOSE: begin
							e_go  = 1'b1;
							e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_CHAR_UNTERM, 8'd0, ts, off, ln,
								tc);
							done  = 1'b1;
						end
						sbt_pkg::M_CESC: begin
							e_go  = 1'b1;
							e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_CHAR_INCOMP, 8'd0, ts, off, ln,
								tc);
							done  = 1'b1;
						end
						default: begin
							cc    = sbt_pkg::close_cls(m);
							e_go  = cc[5];
							e_res = mk(cc[4:0], sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
							done  = 1'b1;
						end
					endcase
				end else begin
					case (m)
						sbt_pkg::M_PLUS: begin
							if (c == "+") begin
								off   = inc_off(off);
								col   = inc_col(col);
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_INCR, sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
								m     = sbt_pkg::M_IDLE;
								done  = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_MINUS: begin
							if (c == "-" || c == ">") begin
								off   = inc_off(off);
								col   = inc_col(col);
								e_go  = 1'b1;
								e_res = mk((c == "-") ? sbt_pkg::TK_DECR : sbt_pkg::TK_ARROW,
									sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
								m     = sbt_pkg::M_IDLE;
								done  = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_SLASH: begin
							if (c == "/") begin
								off  = inc_off(off);
								col  = inc_col(col);
								m    = sbt_pkg::M_COMMENT;
								done = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_EQ, sbt_pkg::M_LESS, sbt_pkg::M_GREATER: begin
							if ((m == sbt_pkg::M_EQ && c == "=") ||
								(m == sbt_pkg::M_LESS && c == "<") ||
								(m == sbt_pkg::M_GREATER && c == ">")) begin
								off   = inc_off(off);
								col   = inc_col(col);
								e_go  = 1'b1;
								e_res = mk((m == sbt_pkg::M_EQ) ? sbt_pkg::TK_EQ :
									(m == sbt_pkg::M_LESS) ? sbt_pkg::TK_SHL : sbt_pkg::TK_SHR,
									sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
								m     = sbt_pkg::M_IDLE;
								done  = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_DOT: begin
							if (sbt_pkg::is_dig(c)) begin
								off  = inc_off(off);
								col  = inc_col(col);
								m    = sbt_pkg::M_NINT;
								done = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_ZERO: begin
							if ((c | sbt_pkg::CH_LOWER) == "b") begin
								off  = inc_off(off);
								col  = inc_col(col);
								m    = sbt_pkg::M_BSTART;
								done = 1'b1;
							end else begin
								m = sbt_pkg::M_NINT;
							end
						end
						sbt_pkg::M_NINT, sbt_pkg::M_NFRAC: begin
							if (sbt_pkg::is_dig(c)) begin
								off  = inc_off(off);
								col  = inc_col(col);
								done = 1'b1;
							end else if (c == "." && m == sbt_pkg::M_NINT) begin
								m    = sbt_pkg::M_NDOT;
								done = 1'b1;
							end else if ((c | sbt_pkg::CH_LOWER) == "e") begin
								m    = sbt_pkg::M_NE;
								done = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_NDOT, sbt_pkg::M_NE: begin
							if (sbt_pkg::is_dig(c)) begin
								off  = inc_off(inc_off(off));
								col  = inc_col(inc_col(col));
								m    = (m == sbt_pkg::M_NDOT) ? sbt_pkg::M_NFRAC : sbt_pkg::M_NEXP;
								done = 1'b1;
							end else if (m == sbt_pkg::M_NE && (c == "+" || c == "-")) begin
								m    = sbt_pkg::M_NESIGN;
								done = 1'b1;
							end else begin
								// held byte is rescanned as a dot or an identifier start
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_NUMBER, sbt_pkg::ERR_NONE, 8'd0, ts, off, ln,
									tc);
								ts    = off;
								tc    = col;
								off   = inc_off(off);
								col   = inc_col(col);
								m     = (m == sbt_pkg::M_NDOT) ? sbt_pkg::M_DOT : sbt_pkg::M_IDENT;
							end
						end
						sbt_pkg::M_NESIGN: begin
							if (sbt_pkg::is_dig(c)) begin
								off  = inc_off(inc_off(inc_off(off)));
								col  = inc_col(inc_col(inc_col(col)));
								m    = sbt_pkg::M_NEXP;
								done = 1'b1;
							end else begin
								off   = inc_off(inc_off(off));
								col   = inc_col(inc_col(col));
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_EXPONENT, 8'd0, ts, off, ln,
									tc);
								m     = sbt_pkg::M_IDLE;
							end
						end
						sbt_pkg::M_NEXP: begin
							if (sbt_pkg::is_dig(c)) begin
								off  = inc_off(off);
								col  = inc_col(col);
								done = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_BSTART: begin
							if (sbt_pkg::is_bin(c)) begin
								off  = inc_off(off);
								col  = inc_col(col);
								m    = sbt_pkg::M_BDIG;
								done = 1'b1;
							end else begin
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_BINARY, 8'd0, ts, off, ln, tc);
								m     = sbt_pkg::M_IDLE;
							end
						end
						sbt_pkg::M_BDIG: begin
							if (sbt_pkg::is_bin(c)) begin
								off  = inc_off(off);
								col  = inc_col(col);
								done = 1'b1;
							end else if (sbt_pkg::is_dig(c) || sbt_pkg::is_alp(c)) begin
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_BINARY, 8'd0, ts, off, ln, tc);
								m     = sbt_pkg::M_IDLE;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_IDENT: begin
							if (sbt_pkg::is_dig(c) || sbt_pkg::is_alp(c)) begin
								off  = inc_off(off);
								col  = inc_col(col);
								done = 1'b1;
							end else begin
								close = 1'b1;
							end
						end
						sbt_pkg::M_STR: begin
							off  = inc_off(off);
							col  = inc_col(col);
							done = 1'b1;
							if (c == "\"") begin
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_STRING, sbt_pkg::ERR_NONE, 8'd0, ts, off, ln,
									tc);
								m     = sbt_pkg::M_IDLE;
							end else if (c == "\\") begin
								m = sbt_pkg::M_STRESC;
							end
						end
						sbt_pkg::M_STRESC: begin
							off   = inc_off(off);
							col   = inc_col(col);
							ev    = sbt_pkg::esc_decode(c);
							e_go  = !ev[8];
							e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_STR_ESC, 8'd0, ts, off, ln, tc);
							m     = sbt_pkg::M_STR;
							done  = 1'b1;
						end
						sbt_pkg::M_COPEN: begin
							off  = inc_off(off);
							col  = inc_col(col);
							done = 1'b1;
							if (c == "\\") begin
								m = sbt_pkg::M_CESC;
							end else begin
								lit = c;
								m   = sbt_pkg::M_CCLOSE;
							end
						end
						sbt_pkg::M_CESC: begin
							off  = inc_off(off);
							col  = inc_col(col);
							ev   = sbt_pkg::esc_decode(c);
							done = 1'b1;
							if (ev[8]) begin
								lit = ev[7:0];
								m   = sbt_pkg::M_CCLOSE;
							end else begin
								e_go  = 1'b1;
								e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_CHAR_ESC, 8'd0, ts, off, ln,
									tc);
								m     = sbt_pkg::M_IDLE;
							end
						end
						sbt_pkg::M_CCLOSE: begin
							off   = inc_off(off);
							col   = inc_col(col);
							e_go  = 1'b1;
							e_res = (c == "'") ?
								mk(sbt_pkg::TK_CHAR, sbt_pkg::ERR_NONE, lit, ts, off, ln, tc) :
								mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_CHAR_UNTERM, 8'd0, ts, off, ln, tc);
							m     = sbt_pkg::M_IDLE;
							done  = 1'b1;
						end
						sbt_pkg::M_COMMENT: begin
							if (c == "\n") begin
								m = sbt_pkg::M_IDLE;
							end else begin
								off  = inc_off(off);
								col  = inc_col(col);
								done = 1'b1;
							end
						end
						default: begin
							// byte starts a new token
							m    = sbt_pkg::M_IDLE;
							ts   = off;
							tc   = col;
							off  = inc_off(off);
							col  = inc_col(col);
							done = 1'b1;
							case (c)
								" ", "\t", sbt_pkg::CH_CR: begin
								end
								"\n": begin
									e_go  = !lnl;
									e_res = mk(sbt_pkg::TK_NEWLINE, sbt_pkg::ERR_NONE, 8'd0, ts, off,
										ln, tc);
									ln    = (ln != sbt_pkg::LINE_MAX) ? ln + 1'b1 : ln;
									col   = 16'd1;
								end
								"+": m = sbt_pkg::M_PLUS;
								"-": m = sbt_pkg::M_MINUS;
								"/": m = sbt_pkg::M_SLASH;
								"=": m = sbt_pkg::M_EQ;
								"<": m = sbt_pkg::M_LESS;
								">": m = sbt_pkg::M_GREATER;
								".": m = sbt_pkg::M_DOT;
								"\"": m = sbt_pkg::M_STR;
								"'": m = sbt_pkg::M_COPEN;
								"0": m = sbt_pkg::M_ZERO;
								"*", "(", ")", "{", "}", "[", "]", ",", ":": begin
									e_go  = 1'b1;
									e_res = mk((c == "*") ? sbt_pkg::TK_MULT :
										(c == "(") ? sbt_pkg::TK_LPAREN :
										(c == ")") ? sbt_pkg::TK_RPAREN :
										(c == "{") ? sbt_pkg::TK_LBRACE :
										(c == "}") ? sbt_pkg::TK_RBRACE :
										(c == "[") ? sbt_pkg::TK_LBRACK :
										(c == "]") ? sbt_pkg::TK_RBRACK :
										(c == ",") ? sbt_pkg::TK_COMMA : sbt_pkg::TK_COLON,
										sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
								end
								default: begin
									if (sbt_pkg::is_dig(c)) begin
										m = sbt_pkg::M_NINT;
									end else if (sbt_pkg::is_alp(c)) begin
										m = sbt_pkg::M_IDENT;
									end else begin
										e_go  = 1'b1;
										e_res = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_UNEXPECTED, 8'd0, ts,
											off, ln, tc);
									end
								end
							endcase
						end
					endcase
				end

				if (close) begin
					cc    = sbt_pkg::close_cls(m);
					e_go  = cc[5];
					e_res = mk(cc[4:0], sbt_pkg::ERR_NONE, 8'd0, ts, off, ln, tc);
					m     = sbt_pkg::M_IDLE;
				end

				if (e_go && cnt < 3'(sbt_pkg::RES_MAX)) begin
					n_res[cnt[1:0]] = e_res;
					cnt = cnt + 1'b1;
					if (e_res.error_code == sbt_pkg::ERR_NONE) begin
						lnl = (e_res.token_class == sbt_pkg::TK_NEWLINE);
					end
				end
			end
		end

		if (cmd_s1) begin
			// eof at the current offset and column
			if (cnt < 3'(sbt_pkg::RES_MAX)) begin
				n_res[cnt[1:0]] = mk(sbt_pkg::TK_EOF, sbt_pkg::ERR_NONE, 8'd0, off, off, ln, col);
				cnt = cnt + 1'b1;
			end
			m   = sbt_pkg::M_IDLE;
			off = '0;
			ln  = 24'd1;
			col = 16'd1;
			ts  = '0;
			tc  = 16'd1;
			lit = 8'd0;
			lnl = 1'b0;
		end

		if (cnt != 3'd0) begin
			n_res[cnt[1:0] - 2'd1].last_of_run = 1'b1;
		end

		n_mode  = m;
		n_off   = off;
		n_line  = ln;
		n_col   = col;
		n_tso   = ts;
		n_tscol = tc;
		n_lit   = lit;
		n_lnl   = lnl;
		n_cnt   = cnt;
	end

	assign out_fire     = tokens.valid && tokens.ready;
	assign out_last     = (3'({1'b0, bidx_q} + 3'd1) == bcnt_q);
	assign b_free       = (bcnt_q == 3'd0) || (out_fire && out_last);
	assign proc         = v_s1 && b_free;
	assign source.ready = !v_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			mode_q  <= sbt_pkg::M_IDLE;
			off_q   <= '0;
			line_q  <= 24'd1;
			col_q   <= 16'd1;
			tso_q   <= '0;
			tscol_q <= 16'd1;
			lit_q   <= 8'd0;
			lnl_q   <= 1'b0;
			bcnt_q  <= 3'd0;
			bidx_q  <= 2'd0;
		end else begin
			if (source.valid && source.ready) begin
				v_s1 <= 1'b1;
			end else if (proc) begin
				v_s1 <= 1'b0;
			end
			if (proc) begin
				mode_q  <= n_mode;
				off_q   <= n_off;
				line_q  <= n_line;
				col_q   <= n_col;
				tso_q   <= n_tso;
				tscol_q <= n_tscol;
				lit_q   <= n_lit;
				lnl_q   <= n_lnl;
			end
			if (proc && n_cnt != 3'd0) begin
				bcnt_q <= n_cnt;
				bidx_q <= 2'd0;
			end else if (out_fire) begin
				if (out_last) begin
					bcnt_q <= 3'd0;
					bidx_q <= 2'd0;
				end else begin
					bidx_q <= bidx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (source.valid && source.ready) begin
			cmd_s1  <= source.cmd;
			byte_s1 <= source.source_byte;
		end
		if (proc && n_cnt != 3'd0) begin
			for (int k = 0; k < sbt_pkg::RES_MAX; k++) begin
				b_q[k] <= n_res[k];
			end
		end
	end

	assign tokens.valid         = (bcnt_q != 3'd0);
	assign tokens.token_class   = b_q[bidx_q].token_class;
	assign tokens.error_code    = b_q[bidx_q].error_code;
	assign tokens.start_offset  = b_q[bidx_q].start_offset;
	assign tokens.token_length  = b_q[bidx_q].token_length;
	assign tokens.line_number   = b_q[bidx_q].line_number;
	assign tokens.column_number = b_q[bidx_q].column_number;
	assign tokens.char_value    = b_q[bidx_q].char_value;
	assign tokens.last_of_run   = b_q[bidx_q].last_of_run;

endmodule
